// ===== rtl/mes_pkg.sv =====
// ----------------------------------------------------------------------------
// mes_pkg: shared types and constants for the min extract store
// Request and result codes, and the command and status bundles passed
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mes_pkg;

   localparam int DATA_W   = 32;  // tdata payload width on both channels
   localparam int STATUS_W = 2;

   // request kind carried on req_tuser
   localparam logic MODE_INSERT  = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   // result status carried on rsp_tuser
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_MIN      = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch request payload
      logic insert;      // append latched value if room
      logic set_empty;   // result: store empty
      logic walk_start;  // rewind the store walk
      logic walk_run;    // advance the store walk
      logic purge;       // walk compacts instead of searching
      logic finish_min;  // commit purge, result: minimum
      logic out_load;    // move result into the output register
   } mes_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;       // no stored entries
      logic walk_done;   // all entries read and processed
      logic out_free;    // output register can take a result
   } mes_sts_type;

endpackage

// ===== rtl/mes_ctrl.sv =====
// ----------------------------------------------------------------------------
// mes_ctrl: request sequencer
// Steps each request through insert, or search and purge for an extract
// on a non-empty store, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mes_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_mode,
   output logic                 req_tready,
   input  mes_pkg::mes_sts_type sts,
   output mes_pkg::mes_cmd_type cmd
);
   import mes_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_EXTRACT,
      S_SCAN,
      S_PURGE,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_mode == MODE_EXTRACT) ? S_EXTRACT : S_INSERT;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_FINISH;
         end
         S_EXTRACT: begin
            if (sts.empty) begin
               cmd.set_empty = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.walk_run = 1'b1;
            if (sts.walk_done) begin
               cmd.walk_start = 1'b1;
               state_in       = S_PURGE;
            end
         end
         S_PURGE: begin
            cmd.walk_run = 1'b1;
            cmd.purge    = 1'b1;
            if (sts.walk_done) begin
               cmd.finish_min = 1'b1;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/mes_dp.sv =====
// ----------------------------------------------------------------------------
// mes_dp: value store and search datapath
// Packed value memory with fill count, min search walk, compaction walk
// that drops every copy of the minimum, and the result output register.
// ----------------------------------------------------------------------------
module mes_dp #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mes_pkg::mes_cmd_type          cmd,
   output mes_pkg::mes_sts_type          sts,
   input  logic [mes_pkg::DATA_W-1:0]    req_tdata,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [mes_pkg::DATA_W-1:0]    rsp_tdata,
   output logic [mes_pkg::STATUS_W-1:0]  rsp_tuser
);
   import mes_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // entries 0 .. count-1 are live; order is irrelevant to results
   logic [VALUE_WIDTH-1:0] mem [DEPTH];

   logic [CNT_W-1:0]        count_ff,   count_in;
   logic [CNT_W-1:0]        rd_idx_ff,  rd_idx_in;
   logic [CNT_W-1:0]        wr_ptr_ff,  wr_ptr_in;
   logic                    pend_ff,    pend_in;
   logic                    first_ff,   first_in;
   logic signed [VALUE_WIDTH-1:0] best_ff, best_in;
   logic [VALUE_WIDTH-1:0]  value_ff;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   status_type              res_status_ff;
   logic [DATA_W-1:0]       res_value_ff;
   logic                    out_valid_ff, out_valid_in;
   status_type              out_status_ff;
   logic [DATA_W-1:0]       out_value_ff;

   logic                    rd_go;
   logic                    full;
   logic                    keep;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0]  wr_data;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign rd_go = cmd.walk_run && (rd_idx_ff != count_ff);
   assign keep  = pend_ff && cmd.purge && (rd_data_ff != best_ff);

   assign sts.empty     = (count_ff == '0);
   assign sts.walk_done = (rd_idx_ff == count_ff) && !pend_ff;
   assign sts.out_free  = !out_valid_ff || rsp_tready;

   // single write port: append on insert, compaction write on purge
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[ADDR_W-1:0];
      wr_data = value_ff;
      if (cmd.insert && !full) begin
         wr_en = 1'b1;
      end else if (keep) begin
         wr_en   = 1'b1;
         wr_addr = wr_ptr_ff[ADDR_W-1:0];
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_go) begin
         rd_data_ff <= mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

   always_comb begin
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      wr_ptr_in = wr_ptr_ff;
      pend_in   = rd_go;
      first_in  = first_ff;
      best_in   = best_ff;
      if (cmd.insert && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.finish_min) begin
         count_in = wr_ptr_ff;
      end
      if (cmd.walk_start) begin
         rd_idx_in = '0;
         wr_ptr_in = '0;
         pend_in   = 1'b0;
         first_in  = 1'b1;
      end else begin
         if (rd_go) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         if (pend_ff && !cmd.purge && (first_ff || (rd_data_ff < best_ff))) begin
            best_in  = rd_data_ff;
            first_in = 1'b0;
         end
         if (keep) begin
            wr_ptr_in = wr_ptr_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         wr_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         wr_ptr_ff    <= wr_ptr_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_ff <= best_in;
      if (cmd.capture) begin
         value_ff <= VALUE_WIDTH'(req_tdata);
      end
      if (cmd.insert) begin
         res_status_ff <= full ? ST_FULL : ST_INSERTED;
         res_value_ff  <= '0;
      end
      if (cmd.set_empty) begin
         res_status_ff <= ST_EMPTY;
         res_value_ff  <= '0;
      end
      if (cmd.finish_min) begin
         res_status_ff <= ST_MIN;
         res_value_ff  <= DATA_W'(best_ff);
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ===== rtl/min_extract_store.sv =====
// ----------------------------------------------------------------------------
// min_extract_store: bounded store of signed values with min extraction
// Insert appends a value; extract returns the smallest stored value and
// removes every entry equal to it. One result transaction per request.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata          | tuser           | notes
//  ---------+-----+----------------+-----------------+--------------------------
//  req_     | in  | value [31:0]   | mode [0]        | 0 insert, 1 extract
//  rsp_     | out | min_value[31:0]| status [1:0]    | 0 ins,1 full,2 min,3 empty
//
//  Insert steps through S_INSERT and S_FINISH; an empty extract through
//  S_EXTRACT and S_FINISH. An extract on stored entries makes one search
//  walk and one compaction walk over the value memory, one entry per cycle
//  through its single registered read port.
//  Reset clears the fill count and control; no memory clearing is needed.
//  A result waiting on rsp_tready does not block the next request; only a
//  second result finished before the first is taken stalls the sequencer.
//
module min_extract_store #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mes_pkg::DATA_W-1:0]    req_tdata,   // [31:0] value
   input  logic [0:0]                    req_tuser,   // [0] mode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mes_pkg::DATA_W-1:0]    rsp_tdata,   // [31:0] min_value
   output logic [mes_pkg::STATUS_W-1:0]  rsp_tuser    // [1:0] status
);
   import mes_pkg::*;

   mes_cmd_type cmd;
   mes_sts_type sts;

   // sequencer: one request in flight at a time
   mes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser[0]),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // store memory, search/purge walk and output register
   mes_dp #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a result is never loaded over one still waiting to be taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over pending transaction");

   // an accepted request keeps the sequencer busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted twice back to back");

   // result-producing commands are mutually exclusive
   a_single_commit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.insert, cmd.set_empty, cmd.finish_min, cmd.walk_start}))
      else $error("conflicting datapath commands");

endmodule

// ===== tb/sv/min_extract_store_test.sv =====
// ----------------------------------------------------------------------------
// min_extract_store_test: self-checking bench for the min extract store
// Streams insert and extract requests with random gaps on both channels,
// mirrors the store in a behavioral copy, and checks every result
// transaction field by field against the copy, in order.
// ----------------------------------------------------------------------------
module min_extract_store_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mes_pkg::*;

   localparam int STORE_DEPTH  = 64;
   localparam int VALUE_BITS   = 32;
   localparam int RANDOM_ITEMS = 400;
   // allow a full-store extract plus the long receiver stall on top
   localparam int QUIET_LIMIT  = 3000;
   localparam int STALL_CYCLES = 300;   // long receiver hold-off, fills the block up
   localparam int DRAIN_CYCLES = 200;   // settle time after the last result

   typedef struct packed {
      logic                  mode;
      logic [VALUE_BITS-1:0] value;
   } request_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] min_value;
   } outcome_type;

   // DUT ports, all inputs known from time zero
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;   // [31:0] value
   logic [0:0]          req_tuser  = '0;   // [0] mode
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;         // [31:0] min_value
   logic [STATUS_W-1:0] rsp_tuser;         // [1:0] status

   // behavioral copy of the store
   logic [VALUE_BITS-1:0] slot_value [STORE_DEPTH];
   bit                    slot_used  [STORE_DEPTH];

   request_type requests_to_send [$];   // filled up front, drained by the driver
   outcome_type outcomes_due [$];       // predicted results, oldest first
   request_type on_wire;                // request currently offered on req_
   outcome_type oldest_due;

   int total_items    = 1;
   int requests_taken = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;
   int stall_left     = 0;
   bit stall_done     = 1'b0;

   min_extract_store #(
      .DEPTH      (STORE_DEPTH),
      .VALUE_WIDTH(VALUE_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Store prediction: insert takes the first free slot; extract returns the
   // signed minimum and frees every slot holding that same value.
   // ------------------------------------------------------------------------
   function automatic outcome_type apply_request(request_type rq);
      outcome_type                  res;
      logic signed [VALUE_BITS-1:0] lowest;
      bit                           placed;
      bit                           found;
      res.status    = ST_FULL;
      res.min_value = '0;
      lowest        = '0;
      placed        = 1'b0;
      found         = 1'b0;
      if (rq.mode == MODE_INSERT) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            if (!placed && !slot_used[i]) begin
               slot_value[i] = rq.value;
               slot_used[i]  = 1'b1;
               placed        = 1'b1;
            end
         end
         // full store: insert dropped, nothing written
         res.status = placed ? ST_INSERTED : ST_FULL;
      end else begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            if (slot_used[i] && (!found || $signed(slot_value[i]) < lowest)) begin
               lowest = slot_value[i];
               found  = 1'b1;
            end
         end
         if (!found) begin
            res.status = ST_EMPTY;
         end else begin
            // duplicate minimum: all copies go
            for (int i = 0; i < STORE_DEPTH; i++) begin
               if (slot_used[i] && slot_value[i] == lowest) begin
                  slot_used[i] = 1'b0;
               end
            end
            res.status    = ST_MIN;
            res.min_value = lowest;
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("MISMATCH @%0t result #%0d: %s", $time, results_seen, msg);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------
   task automatic queue_one(input logic mode, input logic [VALUE_BITS-1:0] value);
      request_type rq;
      rq.mode  = mode;
      rq.value = value;
      requests_to_send = {requests_to_send, rq};
   endtask

   // small pool makes duplicates likely; extremes exercise the signed order
   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v = $urandom_range(0, 15) - 8;
         end
         4: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7fff_ffff;
               2:       v = '0;
               default: v = '1;
            endcase
         end
         default: begin
            v = $urandom();
         end
      endcase
      return v;
   endfunction

   // a run of requests; extract payloads are random since the block ignores them
   task automatic queue_run(input int count, input int insert_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < insert_pct) begin
            queue_one(MODE_INSERT, pick_value());
         end else begin
            queue_one(MODE_EXTRACT, $urandom());
         end
      end
   endtask

   // idle mix by third of the run: sender 21 / receiver 46, then swapped, then none
   function automatic bit sender_idles();
      int third;
      third = (requests_taken * 3) / total_items;
      if (third == 0) return $urandom_range(0, 99) < 21;
      if (third == 1) return $urandom_range(0, 99) < 46;
      return 1'b0;
   endfunction

   function automatic bit receiver_idles();
      int third;
      third = (requests_taken * 3) / total_items;
      if (third == 0) return $urandom_range(0, 99) < 46;
      if (third == 1) return $urandom_range(0, 99) < 21;
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers queued requests on req_, predicts on each accepted
   // transaction. Valid is held until accepted.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcomes_due = {outcomes_due, apply_request(on_wire)};
            requests_taken <= requests_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (requests_to_send.size() > 0 && !sender_idles()) begin
               on_wire = requests_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= on_wire.value;
               req_tuser  <= on_wire.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each result transaction against the oldest prediction
   // and drives rsp_tready, including one long hold-off late in the run.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcomes_due.size() == 0) begin
               note_mismatch($sformatf("unexpected result, status %0d value %h",
                                       rsp_tuser, rsp_tdata));
            end else begin
               oldest_due = outcomes_due.pop_front();
               if (rsp_tuser !== oldest_due.status) begin
                  note_mismatch($sformatf("status %0d, predicted %s",
                                          rsp_tuser, oldest_due.status.name()));
               end
               if (rsp_tdata !== oldest_due.min_value) begin
                  note_mismatch($sformatf("min_value %h, predicted %h",
                                          rsp_tdata, oldest_due.min_value));
               end
            end
            results_seen++;
         end
         // hold-off lands in the no-idle third, so the sender keeps pushing
         if (!stall_done && requests_taken >= (2 * total_items) / 3 + 20) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !receiver_idles();
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: directed cases, a fill past capacity, then random runs
   // ------------------------------------------------------------------------
   initial begin
      int directed;

      // empty store on extract
      queue_one(MODE_EXTRACT, 32'h0);
      // signed extremes, with the most negative value stored twice
      queue_one(MODE_INSERT, 32'h7fff_ffff);
      queue_one(MODE_INSERT, 32'h8000_0000);
      queue_one(MODE_INSERT, 32'hffff_ffff);
      queue_one(MODE_INSERT, 32'h0000_0000);
      queue_one(MODE_INSERT, 32'h8000_0000);
      queue_one(MODE_EXTRACT, 32'h0);   // most negative, both copies freed
      queue_one(MODE_EXTRACT, 32'h0);   // -1
      // triple duplicate above a smaller value
      queue_one(MODE_INSERT, 32'd5);
      queue_one(MODE_INSERT, 32'd5);
      queue_one(MODE_INSERT, 32'd3);
      queue_one(MODE_INSERT, 32'd5);
      queue_one(MODE_EXTRACT, 32'h0);   // 3
      queue_one(MODE_EXTRACT, 32'h0);   // 5, all three freed
      queue_one(MODE_EXTRACT, 32'h0);   // 0
      queue_one(MODE_EXTRACT, 32'h0);   // max positive
      queue_one(MODE_EXTRACT, 32'hffff_ffff);   // empty again, payload ignored
      queue_one(MODE_INSERT, 32'haaaa_aaaa);
      queue_one(MODE_EXTRACT, 32'h5555_5555);
      directed = requests_to_send.size();

      // fill past capacity: the last inserts are dropped as full
      queue_run(STORE_DEPTH + 6, 100);
      while (requests_to_send.size() < directed + RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       queue_run($urandom_range(STORE_DEPTH + 2, STORE_DEPTH + 8), 100);
            1, 2:    queue_run($urandom_range(20, 40), 25);
            default: queue_run($urandom_range(20, 40), 55);
         endcase
      end
      total_items = requests_to_send.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (requests_taken == total_items);
      wait (outcomes_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mes_pkg.sv
rtl/mes_ctrl.sv
rtl/mes_dp.sv
rtl/min_extract_store.sv
tb/sv/min_extract_store_test.sv
